// File: sv/sph_cubic_spline_kernel_unit_defines.svh
// ----------------------------------------------------------------------------
// sph_cubic_spline_kernel_unit_defines.svh
// Assertion macros used by the checker file of the kernel unit.
// ----------------------------------------------------------------------------
`ifndef SPH_CUBIC_SPLINE_KERNEL_UNIT_DEFINES_SVH
`define SPH_CUBIC_SPLINE_KERNEL_UNIT_DEFINES_SVH

// Property clocked on clk and switched off while rst_n is low.
`define SPH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define SPH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// File: sv/sph_pkg.sv
// ----------------------------------------------------------------------------
// sph_pkg
// Types, widths and constants of the cubic spline kernel pipeline.
// ----------------------------------------------------------------------------
package sph_pkg;

    localparam int LANES       = 3;
    localparam int U_W         = 31;              // q in Q.30, q < 2
    localparam int NUM_W       = 32 + U_W;        // r * 2^31
    localparam int MAG_W       = 34;              // |P|
    localparam int C_W         = 32;
    localparam int E_W         = 32;
    localparam int M1_W        = MAG_W + C_W;     // |P| * C
    localparam int PP_W        = 65;              // partial products of M1 * E
    localparam int X0_W        = M1_W + E_W;      // |P| * C * E
    localparam int SHL_MAX     = 85;              // 17 * 5
    localparam int SHW         = X0_W + SHL_MAX;
    localparam int DROP_SCALAR = 32;
    localparam int DROP_GRAD   = 62;
    localparam int XW          = SHW - DROP_SCALAR;
    localparam int SP_W        = 160;             // s^5
    localparam int Q_W         = 64;
    localparam int DW          = SP_W + Q_W;

    localparam logic [C_W-1:0] C_1D = 32'd2863311531;
    localparam logic [C_W-1:0] C_2D = 32'd1953043645;
    localparam logic [C_W-1:0] C_3D = 32'd1367130551;

    localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        OP_VALUE = 3'd0,
        OP_D1    = 3'd1,
        OP_D2    = 3'd2,
        OP_SELF  = 3'd3,
        OP_GRAD  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_SUP = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic [31:0]               s;
        logic [LANES-1:0][E_W-1:0] e;
        logic [2:0]                n;
        logic [C_W-1:0]            cnorm;
        logic                      zero_res;
        logic                      zero_sup;
    } item_t;

    typedef struct packed {
        item_t                    it;
        logic [LANES-1:0]         lneg;
        logic [LANES-1:0][XW-1:0] xq;
    } scaled_t;

    typedef struct packed {
        op_t              op;
        logic             zero_res;
        logic             zero_sup;
        logic [LANES-1:0] lneg;
    } meta_t;

endpackage

// File: sv/sph_udiv.sv
// ----------------------------------------------------------------------------
// sph_udiv
// Restoring divider, one quotient bit a stage: u = floor(r * 2^31 / s).
// ----------------------------------------------------------------------------
module sph_udiv import sph_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [31:0]    in_r,
    input  item_t          in_it,
    output logic           out_valid,
    output logic [U_W-1:0] out_u,
    output item_t          out_it
);

    logic             vld_reg [U_W];
    logic [NUM_W-1:0] rem_reg [U_W];
    logic [U_W-1:0]   quo_reg [U_W];
    item_t            it_reg  [U_W];

    for (genvar j = 0; j < U_W; j++)
    begin : g_stage
        localparam int SH = U_W - 1 - j;
        logic             vld_in;
        logic [NUM_W-1:0] rem_in;
        logic [U_W-1:0]   quo_in;
        item_t            it_in;
        logic [NUM_W-1:0] trial;
        logic             take;

        if (j == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign rem_in = {in_r, {U_W{1'b0}}};
            assign quo_in = '0;
            assign it_in  = in_it;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign it_in  = it_reg[j-1];
        end

        assign trial = NUM_W'(it_in.s) << SH;
        assign take  = rem_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (adv)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j] <= take ? rem_in - trial : rem_in;
                quo_reg[j] <= take ? (quo_in | (U_W'(1) << SH)) : quo_in;
                it_reg[j]  <= it_in;
            end
        end
    end

    assign out_valid = vld_reg[U_W-1];
    assign out_u     = quo_reg[U_W-1];
    assign out_it    = it_reg[U_W-1];

endmodule

// File: sv/sph_poly.sv
// ----------------------------------------------------------------------------
// sph_poly
// Kernel polynomial and its derivatives, then |P| * C * |e| * 2^(17n) / 2^drop.
// ----------------------------------------------------------------------------
module sph_poly import sph_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [U_W-1:0] in_u,
    input  item_t          in_it,
    output logic           out_valid,
    output scaled_t        out_dat
);

    // stage 1: squares
    logic           p1_valid_reg;
    logic [U_W-1:0] p1_u_reg;
    logic [31:0]    p1_w_reg;
    logic [31:0]    p1_sq_reg;
    logic [33:0]    p1_ws_reg;
    item_t          p1_it_reg;
    // stage 2: cubes
    logic           p2_valid_reg;
    logic [U_W-1:0] p2_u_reg;
    logic [31:0]    p2_w_reg;
    logic [31:0]    p2_sq_reg;
    logic [33:0]    p2_ws_reg;
    logic [32:0]    p2_cu_reg;
    logic [35:0]    p2_wc_reg;
    item_t          p2_it_reg;
    // stage 3: polynomial
    logic                      p3_valid_reg;
    logic [MAG_W-1:0]          p3_mag_reg;
    logic [LANES-1:0]          p3_lneg_reg;
    logic [LANES-1:0][E_W-1:0] p3_emag_reg;
    item_t                     p3_it_reg;
    // stage 4: times normalisation
    logic                      p4_valid_reg;
    logic [M1_W-1:0]           p4_m1_reg;
    logic [LANES-1:0]          p4_lneg_reg;
    logic [LANES-1:0][E_W-1:0] p4_emag_reg;
    item_t                     p4_it_reg;
    // stage 5: partial products with the direction
    logic                       p5_valid_reg;
    logic [LANES-1:0][PP_W-1:0] p5_lo_reg;
    logic [LANES-1:0][PP_W-1:0] p5_hi_reg;
    logic [LANES-1:0]           p5_lneg_reg;
    item_t                      p5_it_reg;
    // stage 6: sum of partials
    logic                       p6_valid_reg;
    logic [LANES-1:0][X0_W-1:0] p6_x0_reg;
    logic [LANES-1:0]           p6_lneg_reg;
    item_t                      p6_it_reg;
    // stage 7: shifts
    logic    p7_valid_reg;
    scaled_t p7_dat_reg;

    logic [63:0]      sq_prod;
    logic [63:0]      ws_prod;
    logic [31:0]      w_next;
    logic [62:0]      cu_prod;
    logic [65:0]      wc_prod;
    logic             inner;
    logic [39:0]      mag_wide;
    logic [39:0]      d2_v;
    logic             neg;
    logic [LANES-1:0] lneg_next;
    logic [LANES-1:0][E_W-1:0] emag_next;
    logic [7:0]       shamt;

    assign w_next  = 32'd2147483648 - 32'(in_u);
    assign sq_prod = 64'(in_u) * 64'(in_u);
    assign ws_prod = 64'(w_next) * 64'(w_next);
    assign cu_prod = 63'(p1_sq_reg) * 63'(p1_u_reg);
    assign wc_prod = 66'(p1_ws_reg) * 66'(p1_w_reg);
    assign inner   = !p2_u_reg[U_W-1];
    assign d2_v    = 40'd18 * 40'(p2_u_reg) - (40'd3 << 32);

    always_comb
    begin
        neg      = 1'b0;
        mag_wide = '0;
        case (p2_it_reg.op)
            OP_VALUE:
                mag_wide = inner ? (40'd1 << 32) - 40'd6 * 40'(p2_sq_reg)
                                   + 40'd3 * 40'(p2_cu_reg)
                                 : 40'(p2_wc_reg);
            OP_D1, OP_GRAD:
            begin
                neg      = 1'b1;
                mag_wide = inner ? 40'd12 * 40'(p2_u_reg) - 40'd9 * 40'(p2_sq_reg)
                                 : 40'd3 * 40'(p2_ws_reg);
            end
            OP_D2:
            begin
                if (inner)
                begin
                    neg      = d2_v[39];
                    mag_wide = d2_v[39] ? 40'd0 - d2_v : d2_v;
                end
                else
                begin
                    mag_wide = 40'd6 * 40'(p2_w_reg);
                end
            end
            OP_SELF:
                mag_wide = 40'd1 << 32;
            default:
                mag_wide = '0;
        endcase
    end

    // lane 0 carries the scalar result unless the item asks for a gradient
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            emag_next[l] = p2_it_reg.e[l][E_W-1] ? E_W'(0) - p2_it_reg.e[l]
                                                  : p2_it_reg.e[l];
            lneg_next[l] = neg ^ p2_it_reg.e[l][E_W-1];
        end
        if (p2_it_reg.op != OP_GRAD)
        begin
            emag_next[0] = E_W'(1);
            lneg_next[0] = neg;
        end
    end

    assign shamt = 8'({5'd0, p6_it_reg.n} * 8'd17);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            p6_valid_reg <= 1'b0;
            p7_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            p6_valid_reg <= p5_valid_reg;
            p7_valid_reg <= p6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_u_reg  <= in_u;
            p1_w_reg  <= w_next;
            p1_sq_reg <= sq_prod[61:30];
            p1_ws_reg <= ws_prod[63:30];
            p1_it_reg <= in_it;

            p2_u_reg  <= p1_u_reg;
            p2_w_reg  <= p1_w_reg;
            p2_sq_reg <= p1_sq_reg;
            p2_ws_reg <= p1_ws_reg;
            p2_cu_reg <= cu_prod[62:30];
            p2_wc_reg <= wc_prod[65:30];
            p2_it_reg <= p1_it_reg;

            p3_mag_reg  <= MAG_W'(mag_wide);
            p3_lneg_reg <= lneg_next;
            p3_emag_reg <= emag_next;
            p3_it_reg   <= p2_it_reg;

            p4_m1_reg   <= M1_W'(p3_mag_reg) * M1_W'(p3_it_reg.cnorm);
            p4_lneg_reg <= p3_lneg_reg;
            p4_emag_reg <= p3_emag_reg;
            p4_it_reg   <= p3_it_reg;

            for (int l = 0; l < LANES; l++)
            begin
                p5_lo_reg[l] <= PP_W'(p4_m1_reg[32:0]) * PP_W'(p4_emag_reg[l]);
                p5_hi_reg[l] <= PP_W'(p4_m1_reg[M1_W-1:33]) * PP_W'(p4_emag_reg[l]);
                p6_x0_reg[l] <= (X0_W'(p5_hi_reg[l]) << 33) + X0_W'(p5_lo_reg[l]);
                p7_dat_reg.xq[l] <= XW'((SHW'(p6_x0_reg[l]) << shamt) >>
                    ((p6_it_reg.op == OP_GRAD) ? DROP_GRAD : DROP_SCALAR));
            end
            p5_lneg_reg <= p4_lneg_reg;
            p5_it_reg   <= p4_it_reg;
            p6_lneg_reg <= p5_lneg_reg;
            p6_it_reg   <= p5_it_reg;
            p7_dat_reg.lneg <= p6_lneg_reg;
            p7_dat_reg.it   <= p6_it_reg;
        end
    end

    assign out_valid = p7_valid_reg;
    assign out_dat   = p7_dat_reg;

endmodule

// File: sv/sph_pow.sv
// ----------------------------------------------------------------------------
// sph_pow
// s^n by up to four multiplications by s, limb products then one wide sum.
// ----------------------------------------------------------------------------
module sph_pow import sph_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  scaled_t         in_dat,
    output logic            out_valid,
    output logic [SP_W-1:0] out_spow,
    output scaled_t         out_dat
);

    localparam int STEPS = 4;
    localparam int LIMBS = 4;

    logic                     pa_vld_reg  [STEPS];
    logic [LIMBS-1:0][63:0]   pa_prod_reg [STEPS];
    logic [SP_W-1:0]          pa_acc_reg  [STEPS];
    scaled_t                  pa_dat_reg  [STEPS];
    logic                     pb_vld_reg  [STEPS];
    logic [SP_W-1:0]          pb_acc_reg  [STEPS];
    scaled_t                  pb_dat_reg  [STEPS];

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        logic            vld_in;
        logic [SP_W-1:0] acc_in;
        scaled_t         dat_in;
        logic [SP_W-1:0] sum;

        if (j == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign acc_in = SP_W'(in_dat.it.s);
            assign dat_in = in_dat;
        end
        else
        begin : g_next
            assign vld_in = pb_vld_reg[j-1];
            assign acc_in = pb_acc_reg[j-1];
            assign dat_in = pb_dat_reg[j-1];
        end

        assign sum = SP_W'({pa_prod_reg[j][2], pa_prod_reg[j][0]})
                   + (SP_W'({pa_prod_reg[j][3], pa_prod_reg[j][1]}) << 32);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pa_vld_reg[j] <= 1'b0;
                pb_vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                pa_vld_reg[j] <= vld_in;
                pb_vld_reg[j] <= pa_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int k = 0; k < LIMBS; k++)
                    pa_prod_reg[j][k] <= 64'(acc_in[k*32 +: 32]) * 64'(dat_in.it.s);
                pa_acc_reg[j] <= acc_in;
                pa_dat_reg[j] <= dat_in;
                pb_acc_reg[j] <= (pa_dat_reg[j].it.n > 3'(j + 1)) ? sum : pa_acc_reg[j];
                pb_dat_reg[j] <= pa_dat_reg[j];
            end
        end
    end

    assign out_valid = pb_vld_reg[STEPS-1];
    assign out_spow  = pb_acc_reg[STEPS-1];
    assign out_dat   = pb_dat_reg[STEPS-1];

endmodule

// File: sv/sph_qdiv.sv
// ----------------------------------------------------------------------------
// sph_qdiv
// Three-lane restoring divider by s^n: 64 quotient bits, one per stage,
// after a stage that flags quotients of 2^64 and above.
// ----------------------------------------------------------------------------
module sph_qdiv import sph_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  scaled_t                   in_dat,
    input  logic [SP_W-1:0]           in_spow,
    output logic                      out_valid,
    output logic [LANES-1:0][Q_W-1:0] out_q,
    output logic [LANES-1:0]          out_ovf,
    output meta_t                     out_meta
);

    logic                     h_vld_reg;
    logic [LANES-1:0][XW-1:0] h_rem_reg;
    logic [LANES-1:0]         h_ovf_reg;
    logic [SP_W-1:0]          h_den_reg;
    meta_t                    h_meta_reg;
    logic [LANES-1:0]         ovf_next;

    logic                      vld_reg  [Q_W];
    logic [LANES-1:0][XW-1:0]  rem_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0] quo_reg  [Q_W];
    logic [LANES-1:0]          ovf_reg  [Q_W];
    logic [SP_W-1:0]           den_reg  [Q_W];
    meta_t                     meta_reg [Q_W];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            ovf_next[l] = DW'(in_dat.xq[l]) >= (DW'(in_spow) << Q_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg <= 1'b0;
        else if (adv)
            h_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_rem_reg           <= in_dat.xq;
            h_ovf_reg           <= ovf_next;
            h_den_reg           <= in_spow;
            h_meta_reg.op       <= in_dat.it.op;
            h_meta_reg.zero_res <= in_dat.it.zero_res;
            h_meta_reg.zero_sup <= in_dat.it.zero_sup;
            h_meta_reg.lneg     <= in_dat.lneg;
        end
    end

    for (genvar j = 0; j < Q_W; j++)
    begin : g_stage
        localparam int SH = Q_W - 1 - j;
        logic                      vld_in;
        logic [LANES-1:0][XW-1:0]  rem_in;
        logic [LANES-1:0][Q_W-1:0] quo_in;
        logic [LANES-1:0]          ovf_in;
        logic [SP_W-1:0]           den_in;
        meta_t                     meta_in;
        logic [DW-1:0]             trial;
        logic [LANES-1:0][XW-1:0]  rem_next;
        logic [LANES-1:0][Q_W-1:0] quo_next;

        if (j == 0)
        begin : g_first
            assign vld_in  = h_vld_reg;
            assign rem_in  = h_rem_reg;
            assign quo_in  = '0;
            assign ovf_in  = h_ovf_reg;
            assign den_in  = h_den_reg;
            assign meta_in = h_meta_reg;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign ovf_in  = ovf_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign meta_in = meta_reg[j-1];
        end

        assign trial = DW'(den_in) << SH;

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (DW'(rem_in[l]) >= trial)
                begin
                    rem_next[l] = XW'(DW'(rem_in[l]) - trial);
                    quo_next[l] = quo_in[l] | (Q_W'(1) << SH);
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    quo_next[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (adv)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= rem_next;
                quo_reg[j]  <= quo_next;
                ovf_reg[j]  <= ovf_in;
                den_reg[j]  <= den_in;
                meta_reg[j] <= meta_in;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_q     = quo_reg[Q_W-1];
    assign out_ovf   = ovf_reg[Q_W-1];
    assign out_meta  = meta_reg[Q_W-1];

endmodule

// File: sv/sph_cubic_spline_kernel_unit.sv
// ----------------------------------------------------------------------------
// sph_cubic_spline_kernel_unit
// Cubic spline SPH kernel, one particle pair per item. The unit accepts an
// item in every cycle unless the result side stalls; each result passes
// one input stage, 31 stages of the q divider, seven of polynomial and
// scaling, eight forming s^n, 65 of the divider by s^n (one quotient bit a
// stage) and the output register. A stall on the result side holds the whole
// pipeline in place; s_axis_tready is low only while a finished item waits.
// space_dim is taken with cfg_valid and applies to items accepted after it.
// ----------------------------------------------------------------------------
module sph_cubic_spline_kernel_unit import sph_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,  // distance, support, dir_x, dir_y, dir_z
    input  logic [2:0]   s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata,  // value, grad_x, grad_y, grad_z
    output logic [1:0]   m_axis_tuser,  // status
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data       // space_dim
);

    logic        adv;
    logic [1:0]  space_dim_reg;

    logic        f_valid_reg;
    logic [31:0] f_r_reg;
    item_t       f_it_reg;
    item_t       it_next;
    logic [2:0]  dim;
    logic [2:0]  k;

    logic            ud_valid;
    logic [U_W-1:0]  ud_u;
    item_t           ud_it;
    logic            po_valid;
    scaled_t         po_dat;
    logic            pw_valid;
    logic [SP_W-1:0] pw_spow;
    scaled_t         pw_dat;
    logic                      qd_valid;
    logic [LANES-1:0][Q_W-1:0] qd_q;
    logic [LANES-1:0]          qd_ovf;
    meta_t                     qd_meta;

    logic [LANES-1:0][63:0] lane_res;
    logic [LANES-1:0]       lane_sat;
    logic [255:0]           data_next;
    status_t                status_next;

    logic         out_valid_reg;
    logic [255:0] out_data_reg;
    status_t      out_status_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        it_next.op    = op_t'(s_axis_tuser);
        it_next.s     = s_axis_tdata[63:32];
        it_next.e[0]  = s_axis_tdata[95:64];
        it_next.e[1]  = s_axis_tdata[127:96];
        it_next.e[2]  = s_axis_tdata[159:128];
        case (space_dim_reg)
            2'd1:
            begin
                dim           = 3'd1;
                it_next.cnorm = C_1D;
            end
            2'd2:
            begin
                dim           = 3'd2;
                it_next.cnorm = C_2D;
            end
            default:
            begin
                dim           = 3'd3;
                it_next.cnorm = C_3D;
            end
        endcase
        case (it_next.op)
            OP_D1, OP_GRAD: k = 3'd1;
            OP_D2:          k = 3'd2;
            default:        k = 3'd0;
        endcase
        it_next.n        = dim + k;
        it_next.zero_sup = (s_axis_tdata[63:32] == 32'd0);
        // unused codes, zero support and r >= s (self value aside) give zeros
        it_next.zero_res = it_next.zero_sup || (s_axis_tuser > OP_GRAD)
                        || ((s_axis_tdata[31:0] >= s_axis_tdata[63:32])
                            && (it_next.op != OP_SELF));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_dim_reg <= 2'd3;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                space_dim_reg <= cfg_data;
            if (adv)
            begin
                f_valid_reg   <= s_axis_tvalid;
                out_valid_reg <= qd_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_r_reg        <= s_axis_tdata[31:0];
            f_it_reg       <= it_next;
            out_data_reg   <= data_next;
            out_status_reg <= status_next;
        end
    end

    sph_udiv u_udiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid_reg),
        .in_r      (f_r_reg),
        .in_it     (f_it_reg),
        .out_valid (ud_valid),
        .out_u     (ud_u),
        .out_it    (ud_it)
    );

    sph_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ud_valid),
        .in_u      (ud_u),
        .in_it     (ud_it),
        .out_valid (po_valid),
        .out_dat   (po_dat)
    );

    sph_pow u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (po_valid),
        .in_dat    (po_dat),
        .out_valid (pw_valid),
        .out_spow  (pw_spow),
        .out_dat   (pw_dat)
    );

    sph_qdiv u_qdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pw_valid),
        .in_dat    (pw_dat),
        .in_spow   (pw_spow),
        .out_valid (qd_valid),
        .out_q     (qd_q),
        .out_ovf   (qd_ovf),
        .out_meta  (qd_meta)
    );

    // sign and saturation per lane
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (qd_meta.lneg[l])
            begin
                lane_sat[l] = qd_ovf[l] || (qd_q[l] > NEG_MAX);
                lane_res[l] = lane_sat[l] ? NEG_MAX : 64'd0 - qd_q[l];
            end
            else
            begin
                lane_sat[l] = qd_ovf[l] || qd_q[l][63];
                lane_res[l] = lane_sat[l] ? POS_MAX : qd_q[l];
            end
        end

        if (qd_meta.zero_res)
        begin
            data_next   = '0;
            status_next = qd_meta.zero_sup ? ST_ZERO_SUP : ST_OK;
        end
        else if (qd_meta.op == OP_GRAD)
        begin
            data_next   = {lane_res[2], lane_res[1], lane_res[0], 64'd0};
            status_next = (|lane_sat) ? ST_SAT : ST_OK;
        end
        else
        begin
            data_next   = {192'd0, lane_res[0]};
            status_next = lane_sat[0] ? ST_SAT : ST_OK;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

// File: sv/sph_chk.sv
// ----------------------------------------------------------------------------
// sph_chk
// Port-level checks on the kernel unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sph_cubic_spline_kernel_unit_defines.svh"

module sph_chk import sph_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [255:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a waiting result item holds still
    `SPH_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result item changed")

    // the pipeline takes an item whenever its output stage can move
    `SPH_ASSERT_ALWAYS(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stage")

    // scalar and gradient never both carry data
    `SPH_ASSERT_ALWAYS(a_excl, !m_axis_tvalid || (m_axis_tdata[63:0] == 64'd0) || (m_axis_tdata[255:64] == 192'd0), "value and gradient both nonzero")

    // zero support gives an all-zero item
    `SPH_ASSERT(a_zero_sup, (m_axis_tvalid && (m_axis_tuser == ST_ZERO_SUP)) |-> (m_axis_tdata == 256'd0), "zero support item carries data")

endmodule

bind sph_cubic_spline_kernel_unit sph_chk u_sph_chk (.*);
